### design/amrb_pkg.sv
// ----------------------------------------------------------------------------
// amrb_pkg
// Shared types and codes for the audio meter resync buffer: command, status
// and register index codes, field widths and register reset values.
// ----------------------------------------------------------------------------
package amrb_pkg;

  // Command codes carried in the input tuser
  localparam logic [1:0] CMD_PUSH  = 2'd0;
  localparam logic [1:0] CMD_TICK  = 2'd1;
  localparam logic [1:0] CMD_FLUSH = 2'd2;
  localparam logic [1:0] CMD_POP   = 2'd3;

  // Status codes carried in the output tuser
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_PRIMING   = 3'd2;
  localparam logic [2:0] ST_EMPTY     = 3'd3;
  localparam logic [2:0] ST_UNDRAINED = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] REG_CREDIT   = 3'd0;
  localparam logic [2:0] REG_PREBUF   = 3'd1;
  localparam logic [2:0] REG_INTERVAL = 3'd2;
  localparam logic [2:0] REG_MINSURP  = 3'd3;
  localparam logic [2:0] REG_XFLIMIT  = 3'd4;

  // Field widths
  localparam int unsigned CFG_AW     = 3;
  localparam int unsigned CFG_DW     = 30;
  localparam int unsigned CREDIT_W   = 48;
  localparam int unsigned FIELD_W    = 15;
  localparam int unsigned SAMPLE_W   = 16;

  // Register reset values
  localparam logic [29:0] CREDIT_RST   = 30'd44938971;
  localparam logic [14:0] PREBUF_RST   = 15'd4096;
  localparam logic [3:0]  INTERVAL_RST = 4'd7;
  localparam logic [14:0] MINSURP_RST  = 15'd1024;
  localparam logic [7:0]  XFLIMIT_RST  = 8'd128;

  typedef logic [SAMPLE_W-1:0] sample_t;

endpackage

### design/audio_meter_resync_buffer.sv
// ----------------------------------------------------------------------------
// audio_meter_resync_buffer
// Stereo sample ring metered out once per video tick, with surplus shedding
// and a crossfaded seam.
// ----------------------------------------------------------------------------
// One command is handled at a time; in_tready is high only while the
// sequencer is idle, and the result waits in an output register so the next
// command can be taken while it is still pending. A pop makes one registered
// read of the sample RAM, and a tick may shed surplus with or without a
// crossfade. In a crossfade each sample goes through one shared multiplier
// twice and then a bit-serial divider, and each frame costs two reads and one
// write on the single-read-port sample RAM. The sample RAM needs no clearing.
// ----------------------------------------------------------------------------
module audio_meter_resync_buffer #(
  parameter int unsigned BUFFER_FRAMES = 16384,
  parameter int unsigned RING_DEPTH    = 32768,
  parameter int unsigned MAX_CROSSFADE = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // left_in[15:0], right_in[31:16]
  input  logic [1:0]  in_tuser,   // cmd[1:0]
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // left_out[15:0], right_out[31:16],
                                  // chunk_frames[46:32], shed_frames[61:47],
                                  // level[76:62], zero[79:77]
  output logic [2:0]  out_tuser,  // status[2:0]
  // configuration
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [29:0] cfg_wdata
);

  localparam int unsigned CW0  = $clog2(BUFFER_FRAMES + 1);
  localparam int unsigned CW   = (CW0 > 15) ? CW0 : 15;
  localparam int unsigned PW   = $clog2(RING_DEPTH);
  localparam int unsigned WW   = $clog2(MAX_CROSSFADE + 2);
  localparam int unsigned PRW  = 16 + WW + 1;
  localparam int unsigned NW   = PRW + 1;
  localparam int unsigned DVW  = NW + 1;
  localparam int unsigned DSW  = WW + 2;
  localparam int unsigned DCW  = $clog2(DVW + 1);
  localparam int unsigned NEAR_FULL = (BUFFER_FRAMES * 3) / 4;

  // Sequencer state codes
  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_EXEC     = 5'd1;
  localparam logic [4:0] S_TK_REL   = 5'd2;
  localparam logic [4:0] S_TK_SHED  = 5'd3;
  localparam logic [4:0] S_XF_SETUP = 5'd4;
  localparam logic [4:0] S_XF_HEAD  = 5'd5;
  localparam logic [4:0] S_XF_TAIL  = 5'd6;
  localparam logic [4:0] S_XF_CAPT  = 5'd7;
  localparam logic [4:0] S_XF_M1    = 5'd8;
  localparam logic [4:0] S_XF_M2    = 5'd9;
  localparam logic [4:0] S_XF_M3    = 5'd10;
  localparam logic [4:0] S_XF_DIV   = 5'd11;
  localparam logic [4:0] S_XF_RES   = 5'd12;
  localparam logic [4:0] S_XF_WR    = 5'd13;
  localparam logic [4:0] S_SHED_FIN = 5'd14;
  localparam logic [4:0] S_POP_RD   = 5'd15;
  localparam logic [4:0] S_OUT      = 5'd16;

  // Ring pointer arithmetic, operands below RING_DEPTH
  function automatic logic [PW-1:0] wrap_add(input logic [PW-1:0] a,
                                             input logic [PW-1:0] b);
    logic [PW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (PW+1)'(RING_DEPTH)) s = s - (PW+1)'(RING_DEPTH);
    return s[PW-1:0];
  endfunction

  function automatic logic [PW-1:0] wrap_sub(input logic [PW-1:0] a,
                                             input logic [PW-1:0] b);
    logic [PW:0] s;
    if (a >= b) s = {1'b0, a} - {1'b0, b};
    else        s = {1'b0, a} + (PW+1)'(RING_DEPTH) - {1'b0, b};
    return s[PW-1:0];
  endfunction

  // Configuration registers
  logic [29:0] cpf_r;
  logic [14:0] prebuf_r, minsurp_r;
  logic [3:0]  interval_r;
  logic [7:0]  xflimit_r;

  // Control state
  logic [4:0]            state_r, state_nxt;
  logic [PW-1:0]         wp_r, wp_nxt, rp_r, rp_nxt;
  // Released frames can pile up behind repeated flushes
  logic [31:0]           released_r, released_nxt;
  logic [CW-1:0]         buffered_r, buffered_nxt;
  logic [amrb_pkg::CREDIT_W-1:0] credit_r, credit_nxt;
  logic                  primed_r, primed_nxt;
  logic [3:0]            tss_r, tss_nxt;
  logic [PW-1:0]         gap_pos_r, gap_pos_nxt;
  logic [CW-1:0]         gap_len_r, gap_len_nxt;
  logic                  gap_pend_r, gap_pend_nxt;
  logic                  out_valid_r, out_valid_nxt;

  // Item and result payload
  logic [1:0]            cmd_r, cmd_nxt;
  amrb_pkg::sample_t     lin_r, lin_nxt, rin_r, rin_nxt;
  logic [2:0]            status_r, status_nxt;
  amrb_pkg::sample_t     lo_r, lo_nxt, ro_r, ro_nxt;
  logic [CW-1:0]         chunk_r, chunk_nxt, shed_r, shed_nxt;
  logic [79:0]           out_data_r, out_data_nxt;
  logic [2:0]            out_user_r, out_user_nxt;

  // Crossfade datapath
  logic [PW-1:0]         start_r, start_nxt, tbase_r, tbase_nxt;
  logic [CW-1:0]         drop_r, drop_nxt;
  logic [WW-1:0]         n_r, n_nxt, i_r, i_nxt;
  logic                  ch_r, ch_nxt;
  logic [31:0]           head_r, head_nxt, tail_r, tail_nxt;
  logic signed [PRW-1:0] mul_r, mul_nxt, acc_r, acc_nxt;
  logic [DVW-1:0]        dq_r, dq_nxt;
  logic [DSW-1:0]        rem_r, rem_nxt, dsr_r, dsr_nxt;
  logic [DCW-1:0]        dcnt_r, dcnt_nxt;
  logic                  neg_r, neg_nxt;
  amrb_pkg::sample_t     resl_r, resl_nxt, resr_r, resr_nxt;

  // Combinational helpers
  logic                  in_acc;
  logic [48:0]           credit_sum;
  logic [31:0]           whole, whole_c;
  logic [CW-1:0]         surplus, n_tmp;
  logic                  shed_ok;
  logic [PW-1:0]         head_addr, tail_addr, rp_inc;
  logic signed [15:0]    mul_a;
  logic [WW-1:0]         mul_w;
  logic signed [PRW-1:0] mul_res;
  logic signed [NW-1:0]  num;
  logic [NW-1:0]         num_mag;
  logic [DSW:0]          trial;
  amrb_pkg::sample_t     clamped;

  // RAM port
  logic                  ram_we;
  logic [PW-1:0]         ram_waddr, ram_raddr;
  logic [31:0]           ram_wdata, ram_rdata;

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  assign head_addr = wrap_add(start_r, PW'(i_r));
  assign tail_addr = wrap_add(tbase_r, PW'(i_r));
  assign rp_inc    = wrap_add(rp_r, PW'(1));

  // Shared multiplier: head weight first, then tail weight
  assign mul_a   = (state_r == S_XF_M1)
                   ? $signed(ch_r ? head_r[15:0] : head_r[31:16])
                   : $signed(ch_r ? tail_r[15:0] : tail_r[31:16]);
  assign mul_w   = (state_r == S_XF_M1) ? (n_r - i_r) : (i_r + WW'(1));
  assign mul_res = PRW'(mul_a) * PRW'($signed({1'b0, mul_w}));

  // Rounded blend numerator and magnitude
  assign num     = NW'(acc_r) + NW'(mul_r);
  assign num_mag = num[NW-1] ? NW'(-num) : NW'(num);

  // One restoring division step
  assign trial   = {rem_r, dq_r[DVW-1]};

  // Clamp the signed quotient to 16 bits
  always_comb begin
    if (neg_r) begin
      if (dq_r > DVW'(32768)) clamped = 16'h8000;
      else                    clamped = 16'(~dq_r + DVW'(1));
    end else begin
      if (dq_r > DVW'(32767)) clamped = 16'h7FFF;
      else                    clamped = 16'(dq_r);
    end
  end

  // Tick arithmetic
  assign credit_sum = {1'b0, credit_r} + 49'(cpf_r);
  assign whole      = credit_r[47:16];
  assign whole_c    = (whole > 32'(buffered_r)) ? 32'(buffered_r) : whole;
  assign surplus    = (buffered_r > CW'(prebuf_r)) ? (buffered_r - CW'(prebuf_r))
                                                   : '0;
  assign shed_ok    = (surplus >= CW'(minsurp_r)) &&
                      ((tss_r >= interval_r) || (buffered_r > CW'(NEAR_FULL)));

  // Crossfade length: least of limit, maximum, drop and what follows it
  always_comb begin
    n_tmp = CW'(xflimit_r);
    if (n_tmp > CW'(MAX_CROSSFADE))     n_tmp = CW'(MAX_CROSSFADE);
    if (n_tmp > drop_r)                 n_tmp = drop_r;
    if (n_tmp > buffered_r - drop_r)    n_tmp = buffered_r - drop_r;
  end

  // RAM access steering
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wp_r;
    ram_wdata = {lin_r, rin_r};
    ram_raddr = rp_r;
    if (state_r == S_EXEC && cmd_r == amrb_pkg::CMD_PUSH &&
        buffered_r < CW'(BUFFER_FRAMES)) begin
      ram_we = 1'b1;
    end
    if (state_r == S_XF_WR) begin
      ram_we    = 1'b1;
      ram_waddr = tail_addr;
      ram_wdata = {resl_r, resr_r};
    end
    if (state_r == S_XF_HEAD) ram_raddr = head_addr;
    if (state_r == S_XF_TAIL) ram_raddr = tail_addr;
  end

  amrb_ram #(.WIDTH(32), .DEPTH(RING_DEPTH)) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    wp_nxt        = wp_r;
    rp_nxt        = rp_r;
    released_nxt  = released_r;
    buffered_nxt  = buffered_r;
    credit_nxt    = credit_r;
    primed_nxt    = primed_r;
    tss_nxt       = tss_r;
    gap_pos_nxt   = gap_pos_r;
    gap_len_nxt   = gap_len_r;
    gap_pend_nxt  = gap_pend_r;
    out_valid_nxt = out_valid_r;
    cmd_nxt       = cmd_r;
    lin_nxt       = lin_r;
    rin_nxt       = rin_r;
    status_nxt    = status_r;
    lo_nxt        = lo_r;
    ro_nxt        = ro_r;
    chunk_nxt     = chunk_r;
    shed_nxt      = shed_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    start_nxt     = start_r;
    tbase_nxt     = tbase_r;
    drop_nxt      = drop_r;
    n_nxt         = n_r;
    i_nxt         = i_r;
    ch_nxt        = ch_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    mul_nxt       = mul_r;
    acc_nxt       = acc_r;
    dq_nxt        = dq_r;
    rem_nxt       = rem_r;
    dsr_nxt       = dsr_r;
    dcnt_nxt      = dcnt_r;
    neg_nxt       = neg_r;
    resl_nxt      = resl_r;
    resr_nxt      = resr_r;

    // Drop the result once the consumer takes it
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cmd_nxt    = in_tuser;
          lin_nxt    = in_tdata[15:0];
          rin_nxt    = in_tdata[31:16];
          status_nxt = amrb_pkg::ST_OK;
          lo_nxt     = '0;
          ro_nxt     = '0;
          chunk_nxt  = '0;
          shed_nxt   = '0;
          state_nxt  = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_OUT;
        unique case (cmd_r)
          amrb_pkg::CMD_PUSH: begin
            if (buffered_r >= CW'(BUFFER_FRAMES)) begin
              status_nxt = amrb_pkg::ST_FULL;
            end else begin
              wp_nxt       = wrap_add(wp_r, PW'(1));
              buffered_nxt = buffered_r + CW'(1);
            end
          end
          amrb_pkg::CMD_TICK: begin
            if (released_r != '0) begin
              status_nxt = amrb_pkg::ST_UNDRAINED;
            end else if (!primed_r && buffered_r < CW'(prebuf_r)) begin
              status_nxt = amrb_pkg::ST_PRIMING;
            end else begin
              primed_nxt = 1'b1;
              credit_nxt = credit_sum[48] ? '1 : credit_sum[47:0];
              state_nxt  = S_TK_REL;
            end
          end
          amrb_pkg::CMD_FLUSH: begin
            chunk_nxt    = buffered_r;
            released_nxt = released_r + 32'(buffered_r);
            buffered_nxt = '0;
            credit_nxt   = '0;
            primed_nxt   = 1'b0;
            tss_nxt      = '0;
          end
          amrb_pkg::CMD_POP: begin
            if (released_r == '0) status_nxt = amrb_pkg::ST_EMPTY;
            else                  state_nxt  = S_POP_RD;
          end
          default: state_nxt = S_OUT;
        endcase
      end
      S_TK_REL: begin
        chunk_nxt    = CW'(whole_c);
        credit_nxt   = credit_r - {whole_c, 16'h0000};
        released_nxt = whole_c;
        buffered_nxt = buffered_r - CW'(whole_c);
        if (tss_r != 4'hF) tss_nxt = tss_r + 4'd1;
        state_nxt    = S_TK_SHED;
      end
      S_TK_SHED: begin
        state_nxt = S_OUT;
        if (shed_ok) begin
          shed_nxt = surplus;
          tss_nxt  = '0;
          if (surplus != '0) begin
            drop_nxt  = surplus;
            start_nxt = wrap_sub(wp_r, PW'(buffered_r));
            state_nxt = S_XF_SETUP;
          end
        end
      end
      S_XF_SETUP: begin
        n_nxt     = WW'(n_tmp);
        i_nxt     = '0;
        ch_nxt    = 1'b0;
        tbase_nxt = wrap_add(start_r, PW'(drop_r));
        state_nxt = (n_tmp == '0) ? S_SHED_FIN : S_XF_HEAD;
      end
      S_XF_HEAD: state_nxt = S_XF_TAIL;
      S_XF_TAIL: begin
        head_nxt  = ram_rdata;
        state_nxt = S_XF_CAPT;
      end
      S_XF_CAPT: begin
        tail_nxt  = ram_rdata;
        state_nxt = S_XF_M1;
      end
      S_XF_M1: begin
        mul_nxt   = mul_res;
        state_nxt = S_XF_M2;
      end
      S_XF_M2: begin
        acc_nxt   = mul_r;
        mul_nxt   = mul_res;
        state_nxt = S_XF_M3;
      end
      S_XF_M3: begin
        // Round half away from zero: (2|num| + den) / (2 den)
        neg_nxt   = num[NW-1];
        dq_nxt    = {num_mag, 1'b0} + DVW'(n_r) + DVW'(1);
        dsr_nxt   = {DSW'(n_r) + DSW'(1)} << 1;
        rem_nxt   = '0;
        dcnt_nxt  = DCW'(DVW);
        state_nxt = S_XF_DIV;
      end
      S_XF_DIV: begin
        if (trial >= {1'b0, dsr_r}) begin
          rem_nxt = DSW'(trial - {1'b0, dsr_r});
          dq_nxt  = {dq_r[DVW-2:0], 1'b1};
        end else begin
          rem_nxt = DSW'(trial);
          dq_nxt  = {dq_r[DVW-2:0], 1'b0};
        end
        dcnt_nxt = dcnt_r - DCW'(1);
        if (dcnt_r == DCW'(1)) state_nxt = S_XF_RES;
      end
      S_XF_RES: begin
        if (!ch_r) begin
          resl_nxt  = clamped;
          ch_nxt    = 1'b1;
          state_nxt = S_XF_M1;
        end else begin
          resr_nxt  = clamped;
          state_nxt = S_XF_WR;
        end
      end
      S_XF_WR: begin
        i_nxt     = i_r + WW'(1);
        ch_nxt    = 1'b0;
        state_nxt = (i_r + WW'(1) == n_r) ? S_SHED_FIN : S_XF_HEAD;
      end
      S_SHED_FIN: begin
        buffered_nxt = buffered_r - drop_r;
        gap_pos_nxt  = start_r;
        gap_len_nxt  = drop_r;
        if (released_r == '0) rp_nxt = tbase_r;
        else                  gap_pend_nxt = 1'b1;
        state_nxt    = S_OUT;
      end
      S_POP_RD: begin
        lo_nxt       = ram_rdata[31:16];
        ro_nxt       = ram_rdata[15:0];
        released_nxt = released_r - 32'd1;
        rp_nxt       = rp_inc;
        // Jump the shed gap when the read pointer reaches it
        if (gap_pend_r && rp_inc == gap_pos_r) begin
          rp_nxt       = wrap_add(rp_inc, PW'(gap_len_r));
          gap_pend_nxt = 1'b0;
        end
        state_nxt    = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_user_nxt  = status_r;
          out_data_nxt  = {3'b000, 15'(buffered_r), 15'(shed_r), 15'(chunk_r),
                           ro_r, lo_r};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wp_r        <= '0;
      rp_r        <= '0;
      released_r  <= '0;
      buffered_r  <= '0;
      credit_r    <= '0;
      primed_r    <= 1'b0;
      tss_r       <= '0;
      gap_pos_r   <= '0;
      gap_len_r   <= '0;
      gap_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
      cpf_r       <= amrb_pkg::CREDIT_RST;
      prebuf_r    <= amrb_pkg::PREBUF_RST;
      interval_r  <= amrb_pkg::INTERVAL_RST;
      minsurp_r   <= amrb_pkg::MINSURP_RST;
      xflimit_r   <= amrb_pkg::XFLIMIT_RST;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      rp_r        <= rp_nxt;
      released_r  <= released_nxt;
      buffered_r  <= buffered_nxt;
      credit_r    <= credit_nxt;
      primed_r    <= primed_nxt;
      tss_r       <= tss_nxt;
      gap_pos_r   <= gap_pos_nxt;
      gap_len_r   <= gap_len_nxt;
      gap_pend_r  <= gap_pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          amrb_pkg::REG_CREDIT:   cpf_r      <= cfg_wdata;
          amrb_pkg::REG_PREBUF:   prebuf_r   <= cfg_wdata[14:0];
          amrb_pkg::REG_INTERVAL: interval_r <= cfg_wdata[3:0];
          amrb_pkg::REG_MINSURP:  minsurp_r  <= cfg_wdata[14:0];
          amrb_pkg::REG_XFLIMIT:  xflimit_r  <= cfg_wdata[7:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    lin_r      <= lin_nxt;
    rin_r      <= rin_nxt;
    status_r   <= status_nxt;
    lo_r       <= lo_nxt;
    ro_r       <= ro_nxt;
    chunk_r    <= chunk_nxt;
    shed_r     <= shed_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
    start_r    <= start_nxt;
    tbase_r    <= tbase_nxt;
    drop_r     <= drop_nxt;
    n_r        <= n_nxt;
    i_r        <= i_nxt;
    ch_r       <= ch_nxt;
    head_r     <= head_nxt;
    tail_r     <= tail_nxt;
    mul_r      <= mul_nxt;
    acc_r      <= acc_nxt;
    dq_r       <= dq_nxt;
    rem_r      <= rem_nxt;
    dsr_r      <= dsr_nxt;
    dcnt_r     <= dcnt_nxt;
    neg_r      <= neg_nxt;
    resl_r     <= resl_nxt;
    resr_r     <= resr_nxt;
  end

`ifndef SYNTHESIS
  // Unreleased frames never exceed the buffer size
  a_buf_bound: assert property (@(posedge clk) disable iff (!rst_n)
    buffered_r <= CW'(BUFFER_FRAMES))
    else $error("buffered count above buffer size");

  // No second command is taken while one is in progress
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("command accepted while busy");

  // The ring is written only by a push or a crossfade write-back
  a_ram_we: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_EXEC || state_r == S_XF_WR))
    else $error("unexpected ring write");
`endif

endmodule

### design/amrb_ram.sv
// ----------------------------------------------------------------------------
// amrb_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module amrb_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32768
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
